// ----- rtl/cpid_pkg.sv -----
// cpid_pkg: types, widths and register codes of the clamped pid controller
// used by every module of the block; depends on nothing
package cpid_pkg;

    // gain fraction bits, legal range 8 to 20
    localparam int GAIN_FRACTION_BITS = 16;

    localparam int GAIN_W  = 24;
    localparam int DATA_W  = 32;
    localparam int SLOT_W  = 2;
    localparam int LIM_W   = 16;
    localparam int DRV_LIM_W = 15;
    localparam int DRIVE_W = 16;
    // clamped error and integral, derivative one bit wider
    localparam int ERR_W   = 17;
    localparam int DERIV_W = ERR_W + 1;
    // products and their sum, with headroom for three terms
    localparam int PROD_W  = GAIN_W + 1 + DERIV_W + 2;
    localparam int SUM_W   = PROD_W;
    localparam int QUOT_W  = SUM_W - GAIN_FRACTION_BITS;

    localparam logic [LIM_W-1:0] ERROR_LIMIT_RST = LIM_W'(5000);
    localparam logic [LIM_W-1:0] INTEG_LIMIT_RST = LIM_W'(5000);

    // configuration register codes
    typedef enum logic [2:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_DERIV_GAIN   = 3'd2,
        REG_ERROR_LIMIT  = 3'd3,
        REG_DEAD_ZONE    = 3'd4,
        REG_INTEG_LIMIT  = 3'd5,
        REG_DRIVE_LIMIT  = 3'd6,
        REG_DOUBLE_ERROR = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [GAIN_W-1:0]    prop_gain;
        logic [GAIN_W-1:0]    integ_gain;
        logic [GAIN_W-1:0]    deriv_gain;
        logic [LIM_W-1:0]     error_limit;
        logic [LIM_W-1:0]     dead_zone;
        logic [LIM_W-1:0]     integ_limit;
        logic [DRV_LIM_W-1:0] drive_limit;
        logic                 double_error;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0] feedback;
        logic signed [DATA_W-1:0] setpoint;
        logic [SLOT_W-1:0]        slot;
    } t_in_word;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic [SLOT_W-1:0]         slot_out;
    } t_out_word;

    // error stage result
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [ERR_W-1:0]   integ;
        logic signed [DERIV_W-1:0] deriv;
        logic [SLOT_W-1:0]         slot;
    } t_err_word;

    // weighted sum before scaling
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SLOT_W-1:0]       slot;
    } t_sum_word;

endpackage

// ----- rtl/cpid_cfg_regs.sv -----
// cpid_cfg_regs: configuration register file of the clamped pid controller
// depends on cpid_pkg
module cpid_cfg_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [cpid_pkg::GAIN_W-1:0] i_cfg_data,
    output cpid_pkg::t_cfg        o_cfg
);
    import cpid_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_PROP_GAIN:    n_cfg.prop_gain    = i_cfg_data;
                REG_INTEG_GAIN:   n_cfg.integ_gain   = i_cfg_data;
                REG_DERIV_GAIN:   n_cfg.deriv_gain   = i_cfg_data;
                REG_ERROR_LIMIT:  n_cfg.error_limit  = i_cfg_data[LIM_W-1:0];
                REG_DEAD_ZONE:    n_cfg.dead_zone    = i_cfg_data[LIM_W-1:0];
                REG_INTEG_LIMIT:  n_cfg.integ_limit  = i_cfg_data[LIM_W-1:0];
                REG_DRIVE_LIMIT:  n_cfg.drive_limit  = i_cfg_data[DRV_LIM_W-1:0];
                REG_DOUBLE_ERROR: n_cfg.double_error = i_cfg_data[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain    <= '0;
            r_cfg.integ_gain   <= '0;
            r_cfg.deriv_gain   <= '0;
            r_cfg.error_limit  <= ERROR_LIMIT_RST;
            r_cfg.dead_zone    <= '0;
            r_cfg.integ_limit  <= INTEG_LIMIT_RST;
            r_cfg.drive_limit  <= '0;
            r_cfg.double_error <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/cpid_err_stage.sv -----
// cpid_err_stage: input register, error clamp, deadband, integral and derivative
// holds the integral and last error state; depends on cpid_pkg
module cpid_err_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cpid_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cpid_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cpid_pkg::t_err_word  o_data
);
    import cpid_pkg::*;

    t_in_word                r_in;
    logic                    r_in_valid;
    t_err_word               r_err;
    logic                    r_err_valid;
    logic signed [ERR_W-1:0] r_integ;
    logic signed [ERR_W-1:0] r_prev;

    logic                      ready_err;
    logic                      ready_in;
    logic                      advance;
    logic signed [DATA_W:0]    diff;
    logic signed [DATA_W+1:0]  raw;
    logic signed [DATA_W+1:0]  err_lim;
    logic signed [ERR_W-1:0]   err_clamped;
    logic signed [DERIV_W-1:0] err_ext;
    logic signed [DERIV_W-1:0] dz;
    logic signed [ERR_W-1:0]   n_err;
    logic signed [DERIV_W-1:0] integ_sum;
    logic signed [DERIV_W-1:0] integ_lim;
    logic signed [ERR_W-1:0]   n_integ;
    logic signed [DERIV_W-1:0] n_deriv;

    // pipeline handshake
    assign ready_err = !r_err_valid || !i_stall;
    assign ready_in  = !r_in_valid || ready_err;
    assign advance   = r_in_valid && ready_err;
    assign o_stall   = !ready_in;
    assign o_valid   = r_err_valid;
    assign o_data    = r_err;

    // exact error, optional doubling, magnitude clamp
    always_comb begin
        diff    = $signed({r_in.setpoint[DATA_W-1], r_in.setpoint}
                        - {r_in.feedback[DATA_W-1], r_in.feedback});
        raw     = i_cfg.double_error ? {diff, 1'b0} : {diff[DATA_W], diff};
        err_lim = $signed({(DATA_W + 2 - LIM_W)'(0), i_cfg.error_limit});
        if (raw > err_lim) begin
            err_clamped = err_lim[ERR_W-1:0];
        end else if (raw < -err_lim) begin
            err_clamped = ERR_W'(-err_lim);
        end else begin
            err_clamped = raw[ERR_W-1:0];
        end
    end

    // deadband, integral clamp and derivative
    always_comb begin
        err_ext = {err_clamped[ERR_W-1], err_clamped};
        dz      = $signed({2'b00, i_cfg.dead_zone});
        if ((err_ext > 0 && err_ext < dz) || (err_ext < 0 && err_ext > -dz)) begin
            n_err = '0;
        end else begin
            n_err = err_clamped;
        end
        integ_sum = {r_integ[ERR_W-1], r_integ} + {n_err[ERR_W-1], n_err};
        integ_lim = $signed({2'b00, i_cfg.integ_limit});
        if (integ_sum > integ_lim) begin
            n_integ = integ_lim[ERR_W-1:0];
        end else if (integ_sum < -integ_lim) begin
            n_integ = ERR_W'(-integ_lim);
        end else begin
            n_integ = integ_sum[ERR_W-1:0];
        end
        n_deriv = {n_err[ERR_W-1], n_err} - {r_prev[ERR_W-1], r_prev};
    end

    // valid bits and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_err_valid <= 1'b0;
            r_integ     <= '0;
            r_prev      <= '0;
        end else begin
            if (ready_in) begin
                r_in_valid <= i_valid;
            end
            if (ready_err) begin
                r_err_valid <= r_in_valid;
            end
            if (advance) begin
                r_integ <= n_integ;
                r_prev  <= n_err;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (ready_in && i_valid) begin
            r_in <= i_data;
        end
        if (advance) begin
            r_err.err   <= n_err;
            r_err.integ <= n_integ;
            r_err.deriv <= n_deriv;
            r_err.slot  <= r_in.slot;
        end
    end

endmodule

// ----- rtl/cpid_mac_stage.sv -----
// cpid_mac_stage: three gain products, registered, then their registered sum
// depends on cpid_pkg
module cpid_mac_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cpid_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cpid_pkg::t_err_word  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cpid_pkg::t_sum_word  o_data
);
    import cpid_pkg::*;

    logic signed [PROD_W-1:0] r_prop;
    logic signed [PROD_W-1:0] r_integ;
    logic signed [PROD_W-1:0] r_deriv;
    logic [SLOT_W-1:0]        r_slot;
    logic                     r_prod_valid;
    t_sum_word                r_sum;
    logic                     r_sum_valid;

    logic                     ready_sum;
    logic                     ready_prod;
    logic signed [PROD_W-1:0] n_prop;
    logic signed [PROD_W-1:0] n_integ;
    logic signed [PROD_W-1:0] n_deriv;
    logic signed [SUM_W-1:0]  n_sum;

    assign ready_sum  = !r_sum_valid || !i_stall;
    assign ready_prod = !r_prod_valid || ready_sum;
    assign o_stall    = !ready_prod;
    assign o_valid    = r_sum_valid;
    assign o_data     = r_sum;

    // gain products, gains taken as positive
    always_comb begin
        n_prop  = $signed({1'b0, i_cfg.prop_gain})  * i_data.err;
        n_integ = $signed({1'b0, i_cfg.integ_gain}) * i_data.integ;
        n_deriv = $signed({1'b0, i_cfg.deriv_gain}) * i_data.deriv;
        n_sum   = r_prop + r_integ + r_deriv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_sum_valid  <= 1'b0;
        end else begin
            if (ready_prod) begin
                r_prod_valid <= i_valid;
            end
            if (ready_sum) begin
                r_sum_valid <= r_prod_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_prod && i_valid) begin
            r_prop  <= n_prop;
            r_integ <= n_integ;
            r_deriv <= n_deriv;
            r_slot  <= i_data.slot;
        end
        if (ready_sum && r_prod_valid) begin
            r_sum.sum  <= n_sum;
            r_sum.slot <= r_slot;
        end
    end

endmodule

// ----- rtl/cpid_out_stage.sv -----
// cpid_out_stage: scaling toward zero, drive clamp and result register
// depends on cpid_pkg
module cpid_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cpid_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cpid_pkg::t_sum_word  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cpid_pkg::t_out_word  o_data
);
    import cpid_pkg::*;

    t_out_word r_out;
    logic      r_out_valid;

    logic                      ready_out;
    logic signed [QUOT_W-1:0]  quot;
    logic signed [QUOT_W-1:0]  quot_adj;
    logic signed [QUOT_W-1:0]  drv_lim;
    logic                      round_up;
    logic signed [DRIVE_W-1:0] n_drive;

    assign ready_out = !r_out_valid || !i_stall;
    assign o_stall   = !ready_out;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    // floor shift, then step back toward zero for negative sums with a fraction
    always_comb begin
        quot     = i_data.sum[SUM_W-1:GAIN_FRACTION_BITS];
        round_up = i_data.sum[SUM_W-1] && (|i_data.sum[GAIN_FRACTION_BITS-1:0]);
        quot_adj = quot + $signed({{(QUOT_W-1){1'b0}}, round_up});
        drv_lim  = $signed({(QUOT_W - DRV_LIM_W)'(0), i_cfg.drive_limit});
        if (quot_adj > drv_lim) begin
            n_drive = drv_lim[DRIVE_W-1:0];
        end else if (quot_adj < -drv_lim) begin
            n_drive = DRIVE_W'(-drv_lim);
        end else begin
            n_drive = quot_adj[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ready_out) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_out && i_valid) begin
            r_out.drive    <= n_drive;
            r_out.slot_out <= i_data.slot;
        end
    end

endmodule

// ----- rtl/clamped_pid_controller_top.sv -----
// Clamped PID controller: takes one word of feedback, setpoint and motor slot
// in every clock cycle while not stalled and returns one 16 bit drive word
// with its slot per word. An accepted word passes in order through the
// pipeline of input register, error and integral register, product register,
// sum register and result register, and each stage moves on as soon
// as the stage after it has room, so a stalled output still lets words enter
// until all five registers are full. The integral and last error are updated
// by the error stage once per word, which sets the rate of one word per cycle
// if unstalled. Configuration writes are always ready and take effect at once;
// write them only while no word is in flight. No clearing pass after reset.
// depends on cpid_pkg and the cpid stage modules
module clamped_pid_controller_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  cpid_pkg::t_in_word            i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output cpid_pkg::t_out_word           o_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [cpid_pkg::GAIN_W-1:0]   i_cfg_data
);
    import cpid_pkg::*;

    t_cfg      cfg;
    t_err_word err_word;
    t_sum_word sum_word;
    logic      err_valid;
    logic      err_stall;
    logic      sum_valid;
    logic      sum_stall;

    // configuration registers
    cpid_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // error, integral and derivative
    cpid_err_stage u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (err_valid),
        .i_stall (err_stall),
        .o_data  (err_word)
    );

    // gain products and sum
    cpid_mac_stage u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (err_valid),
        .o_stall (err_stall),
        .i_data  (err_word),
        .o_valid (sum_valid),
        .i_stall (sum_stall),
        .o_data  (sum_word)
    );

    // scaling, clamp and result register
    cpid_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (sum_valid),
        .o_stall (sum_stall),
        .i_data  (sum_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // input is held back only when a result is waiting at the output
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with no result waiting");

    // drive limit is at most 32767, so the most negative code never appears
    a_drive_not_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.drive != 16'sh8000))
        else $error("drive word outside the clamp range");

    // reset empties the pipeline
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule
